>>> rtl/core/qvr_pkg.sv
package qvr_pkg;

  // extra quotient bit beyond the result width, enough to see saturation
  localparam int DIV_GUARD = 1;
  // headroom bits of the rotation numerator over the raw product widths
  localparam int NUM_GUARD = 4;
  // register stages ahead of the divider and behind it
  localparam int PRE_STAGES  = 4;
  localparam int POST_STAGES = 1;

endpackage

>>> rtl/core/qvr_if.sv
interface qvr_in_if #(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [VEC_WIDTH-1:0]  vec_x;
  logic signed [VEC_WIDTH-1:0]  vec_y;
  logic signed [VEC_WIDTH-1:0]  vec_z;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qvr_out_if #(
  parameter int VEC_WIDTH = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] rot_x;
  logic signed [VEC_WIDTH-1:0] rot_y;
  logic signed [VEC_WIDTH-1:0] rot_z;
  logic                        zero_quat;
  logic                        clipped;

  modport source (output valid, rot_x, rot_y, rot_z, zero_quat, clipped, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, zero_quat, clipped, output ready);
endinterface

>>> rtl/core/qvr_div.sv
module qvr_div #(
  parameter int RW = 54,
  parameter int DW = 35,
  parameter int QB = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] n2,
  input  logic [DW-1:0] d2,
  input  logic          neg,
  output logic [QB-1:0] q,
  output logic          ovf,
  output logic          neg_o
);

  logic [RW-1:0] rem_r [QB];
  logic [DW-1:0] d2_r  [QB];
  logic [QB-1:0] q_r   [QB];
  logic          ovf_r [QB];
  logic          neg_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [DW-1:0] d2_in;
    logic [QB-1:0] q_in;
    logic          ovf_in;
    logic          neg_in;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [QB-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = n2;
      assign d2_in  = d2;
      assign q_in   = '0;
      assign ovf_in = ((n2 >> QB) >= RW'(d2));
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign d2_in  = d2_r[k-1];
      assign q_in   = q_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    // restoring step on quotient bit QB-1-k
    always_comb begin
      ge      = ((rem_in >> (QB - 1 - k)) >= RW'(d2_in));
      rem_nxt = ge ? rem_in - (RW'(d2_in) << (QB - 1 - k)) : rem_in;
      q_nxt   = {q_in[QB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        d2_r[k]  <= d2_in;
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_in;
        neg_r[k] <= neg_in;
      end
    end
  end

  assign q     = q_r[QB-1];
  assign ovf   = ovf_r[QB-1];
  assign neg_o = neg_r[QB-1];

endmodule

>>> rtl/core/quaternion_vector_rotate.sv
// throughput: one transaction per cycle; the whole pipeline advances together
// and holds while a result waits on a stalled output
// the divider is one quotient bit per stage, which sets the depth
// reset (synchronous, active low) clears the stage valid bits only
module quaternion_vector_rotate #(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qvr_in_if.sink    in_ch,
  qvr_out_if.source out_ch
);

  localparam int Q  = QUAT_WIDTH;
  localparam int V  = VEC_WIDTH;
  localparam int QB = V + qvr_pkg::DIV_GUARD;
  localparam int SW = 2 * Q + 2;
  localparam int XW = Q + V + 2;
  localparam int NW = 2 * Q + V + qvr_pkg::NUM_GUARD;
  localparam int RW = NW + 2;
  localparam int DW = SW + 1;
  localparam int NS = qvr_pkg::PRE_STAGES + QB + qvr_pkg::POST_STAGES;

  logic          adv;
  logic          vld_r [NS];
  logic          zq_r  [NS];

  assign adv         = !vld_r[NS-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zq_r[0] <= (in_ch.quat_x == '0) && (in_ch.quat_y == '0) &&
                 (in_ch.quat_z == '0) && (in_ch.quat_w == '0);
      for (int i = 1; i < NS; i++) zq_r[i] <= zq_r[i-1];
    end
  end

  // stage 1: QUAT_WIDTH x QUAT_WIDTH and QUAT_WIDTH x VEC_WIDTH products (16x16 at defaults)
  logic signed [Q-1:0]   u_in [3];
  logic signed [V-1:0]   v_in [3];
  logic signed [2*Q-1:0] sq_r [4];
  logic signed [Q+V-1:0] uv_r [3][3];
  logic signed [Q-1:0]   u1_r [3];
  logic signed [Q-1:0]   w1_r;
  logic signed [V-1:0]   v1_r [3];

  assign u_in[0] = in_ch.quat_x;
  assign u_in[1] = in_ch.quat_y;
  assign u_in[2] = in_ch.quat_z;
  assign v_in[0] = in_ch.vec_x;
  assign v_in[1] = in_ch.vec_y;
  assign v_in[2] = in_ch.vec_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= u_in[i] * u_in[i];
        u1_r[i] <= u_in[i];
        v1_r[i] <= v_in[i];
        for (int j = 0; j < 3; j++) uv_r[i][j] <= u_in[i] * v_in[j];
      end
      sq_r[3] <= in_ch.quat_w * in_ch.quat_w;
      w1_r    <= in_ch.quat_w;
    end
  end

  // stage 2: norms, dot and cross
  logic signed [SW-1:0] uu;
  logic signed [SW-1:0] s2_r;
  logic signed [SW-1:0] den2_r;
  logic signed [XW-1:0] dot2_r;
  logic signed [XW-1:0] cr2_r [3];
  logic signed [Q-1:0]  u2_r  [3];
  logic signed [Q-1:0]  w2_r;
  logic signed [V-1:0]  v2_r  [3];

  assign uu = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r     <= SW'(sq_r[3]) - uu;
      den2_r   <= SW'(sq_r[3]) + uu;
      dot2_r   <= XW'(uv_r[0][0]) + XW'(uv_r[1][1]) + XW'(uv_r[2][2]);
      cr2_r[0] <= XW'(uv_r[1][2]) - XW'(uv_r[2][1]);
      cr2_r[1] <= XW'(uv_r[2][0]) - XW'(uv_r[0][2]);
      cr2_r[2] <= XW'(uv_r[0][1]) - XW'(uv_r[1][0]);
      u2_r     <= u1_r;
      w2_r     <= w1_r;
      v2_r     <= v1_r;
    end
  end

  // stage 3: wide products
  logic signed [SW+V-1:0] a3_r [3];
  logic signed [XW+Q-1:0] b3_r [3];
  logic signed [XW+Q-1:0] c3_r [3];
  logic signed [SW-1:0]   den3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a3_r[k] <= s2_r * v2_r[k];
        b3_r[k] <= dot2_r * u2_r[k];
        c3_r[k] <= cr2_r[k] * w2_r;
      end
      den3_r <= den2_r;
    end
  end

  // stage 4: numerator, sign split, rounding offset
  logic signed [NW-1:0] num  [3];
  logic        [NW-1:0] mag  [3];
  logic        [RW-1:0] n2_r [3];
  logic                 neg4_r [3];
  logic        [DW-1:0] d2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = NW'(a3_r[k]) + (NW'(b3_r[k]) <<< 1) - (NW'(c3_r[k]) <<< 1);
      mag[k] = num[k][NW-1] ? NW'(-num[k]) : NW'(num[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        n2_r[k]   <= RW'({mag[k], 1'b0}) + RW'($unsigned(den3_r));
        neg4_r[k] <= num[k][NW-1];
      end
      d2_r <= {$unsigned(den3_r), 1'b0};
    end
  end

  // divider lanes
  logic [QB-1:0] qd   [3];
  logic          ovfd [3];
  logic          negd [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    qvr_div #(
      .RW (RW),
      .DW (DW),
      .QB (QB)
    ) u_div (
      .clk   (clk),
      .en    (adv),
      .n2    (n2_r[k]),
      .d2    (d2_r),
      .neg   (neg4_r[k]),
      .q     (qd[k]),
      .ovf   (ovfd[k]),
      .neg_o (negd[k])
    );
  end

  // output stage: saturate and restore sign, force zero for a zero quaternion
  logic [QB-1:0]        lim  [3];
  logic [QB-1:0]        qs   [3];
  logic                 clk_k [3];
  logic signed [V-1:0]  rot_nxt [3];
  logic                 clip_nxt;
  logic signed [V-1:0]  rot_r [3];
  logic                 clip_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lim[k]   = negd[k] ? (QB'(1) << (V - 1)) : (QB'(1) << (V - 1)) - QB'(1);
      clk_k[k] = ovfd[k] || (qd[k] > lim[k]);
      qs[k]    = clk_k[k] ? lim[k] : qd[k];
      rot_nxt[k] = negd[k] ? -V'(qs[k]) : V'(qs[k]);
      if (zq_r[NS-2]) rot_nxt[k] = '0;
    end
    clip_nxt = !zq_r[NS-2] && (clk_k[0] || clk_k[1] || clk_k[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r  <= rot_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_ch.valid     = vld_r[NS-1];
  assign out_ch.rot_x     = rot_r[0];
  assign out_ch.rot_y     = rot_r[1];
  assign out_ch.rot_z     = rot_r[2];
  assign out_ch.zero_quat = zq_r[NS-1];
  assign out_ch.clipped   = clip_r;

endmodule

>>> rtl/core/qvr_checker.sv
module qvr_checker #(
  parameter int VEC_WIDTH = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [VEC_WIDTH-1:0] rot_x,
  input logic [VEC_WIDTH-1:0] rot_y,
  input logic [VEC_WIDTH-1:0] rot_z,
  input logic                 zero_quat,
  input logic                 clipped
);

  // stalled transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y) &&
    $stable(rot_z) && $stable(zero_quat) && $stable(clipped))
    else $error("stalled result changed");

  // zero quaternion gives zero vector, no clip
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_quat |-> rot_x == '0 && rot_y == '0 && rot_z == '0 && !clipped)
    else $error("zero quaternion result not zero");

  // a stalled output backpressures the input
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // ready follows the output side once out of reset
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind quaternion_vector_rotate qvr_checker #(.VEC_WIDTH(VEC_WIDTH)) u_qvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rot_x     (out_ch.rot_x),
  .rot_y     (out_ch.rot_y),
  .rot_z     (out_ch.rot_z),
  .zero_quat (out_ch.zero_quat),
  .clipped   (out_ch.clipped)
);
